// ===== rtl/kts_pkg.sv =====
// shared types, constants and helper functions of the keyframe track sampler
`default_nettype none

package kts_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ITER_W       = 5;
    localparam int KEY_W        = 192;

    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [49:0] NEAR_ONE_Q28 = 50'sd268369920;

    localparam logic [1:0] STATUS_INSIDE = 2'd0;
    localparam logic [1:0] STATUS_BEFORE = 2'd1;
    localparam logic [1:0] STATUS_AFTER  = 2'd2;
    localparam logic [1:0] STATUS_ZERO   = 2'd3;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic [47:0] scale;
        logic [63:0] rotation;
        logic [47:0] position;
        logic [31:0] key_time;
    } t_key;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_TPREP,
        S_DIV,
        S_LMUL,
        S_LACC,
        S_DMUL,
        S_DACC,
        S_DSIGN,
        S_SQMUL,
        S_SQCAP,
        S_SQRT,
        S_CORD,
        S_AMUL0,
        S_AMUL1,
        S_AMUL2,
        S_NMUL0,
        S_NMUL1,
        S_NMUL2,
        S_QDIV,
        S_QFIN,
        S_OUT
    } t_state;

    // arctangent of 2^-i in q30
    function automatic logic signed [33:0] atan_q30(input logic [ITER_W-1:0] idx);
        logic signed [33:0] v;
        unique case (idx)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048576;
            5'd11:   v = 34'sd524288;
            5'd12:   v = 34'sd262144;
            5'd13:   v = 34'sd131072;
            5'd14:   v = 34'sd65536;
            5'd15:   v = 34'sd32768;
            5'd16:   v = 34'sd16384;
            5'd17:   v = 34'sd8192;
            5'd18:   v = 34'sd4096;
            5'd19:   v = 34'sd2048;
            5'd20:   v = 34'sd1024;
            5'd21:   v = 34'sd512;
            5'd22:   v = 34'sd256;
            5'd23:   v = 34'sd128;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] comp16(input logic [63:0] v, input logic [1:0] k);
        return v[16*k +: 16];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [49:0] v);
        logic [15:0] r;
        if (v > 50'sd32767) begin
            r = 16'h7fff;
        end else if (v < -50'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/kts_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module kts_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/keyframe_track_sampler_top.sv =====
// keyframe track sampler: key store, interval search, lerp and cordic slerp sequencer
// load word: accepted while idle, ready again the next cycle, no result.
// sample word: the linear search visits the keys one by one, each through a fetch and a check of
// the registered key ram read port; the
// cordic unit and the shared multiplier run every step one after the other; near-equal
// quaternions skip sqrt and cordic. one word in flight: not ready until the result is taken.
// synchronous active-low reset clears the sequencer and sets key_count to 1; key ram is not cleared.
`default_nettype none

module keyframe_track_sampler_top
    import kts_pkg::*;
#(
    parameter int MAX_KEYS         = 32,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [5:0]   i_cfg_wr_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // key_index, key_time, key_position, key_rotation, key_scale, sample_time, zero pad
    input  wire logic [231:0] s_axis_tdata,
    // func
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // position_out, rotation_out, scale_out, sample_status, zero pad
    output logic      [167:0] m_axis_tdata
);

    localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ANGLE_ITERATIONS - 1);

    t_state r_state, n_state;

    logic [5:0]        r_key_count;
    logic [ADDR_W-1:0] r_nlast, r_addr;
    logic [31:0]       r_st;
    t_key              r_ka, r_kb;
    logic [16:0]       r_t;
    logic [1:0]        r_status;
    logic [31:0]       r_rem, r_den;
    logic [ITER_W-1:0] r_cnt;
    logic [3:0]        r_k;
    logic signed [62:0] r_prod;
    logic signed [49:0] r_acc;
    logic              r_negb;
    logic [27:0]       r_d;
    logic [56:0]       r_sqv;
    logic [57:0]       r_res;
    logic [28:0]       r_s;
    logic signed [33:0] r_cx, r_cy, r_cz, r_sa, r_angb;
    logic [1:0]        r_phase;
    logic [49:0]       r_qrem;
    logic [17:0]       r_q;
    logic              r_qneg;
    logic [47:0]       r_pos, r_scl;
    logic [63:0]       r_rot;

    logic              w_in_acc, w_out_acc;
    logic              w_wr_en;
    logic [31:0]       w_idx_ext, w_n;
    logic [ADDR_W-1:0] w_wr_addr;
    t_key              w_wkey, w_rd;
    logic [KEY_W-1:0]  w_rd_raw;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    assign w_idx_ext = 32'(s_axis_tdata[4:0]);
    assign w_wr_addr = w_idx_ext[ADDR_W-1:0];
    assign w_wr_en   = w_in_acc && (s_axis_tuser == FUNC_LOAD) && (w_idx_ext < 32'(MAX_KEYS));

    always_comb begin
        w_wkey.key_time = s_axis_tdata[36:5];
        w_wkey.position = s_axis_tdata[84:37];
        w_wkey.rotation = s_axis_tdata[148:85];
        w_wkey.scale    = s_axis_tdata[196:149];
    end

    kts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wkey),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_raw)
    );

    assign w_rd = w_rd_raw;

    // effective key count, clamped to 1..MAX_KEYS
    always_comb begin
        w_n = (r_key_count == 6'd0) ? 32'd1 : 32'(r_key_count);
        if (w_n > 32'(MAX_KEYS)) begin
            w_n = 32'(MAX_KEYS);
        end
    end

    // component selection
    logic [1:0]         w_qi;
    logic signed [15:0] w_qa, w_qb;
    logic signed [16:0] w_qb17, w_ca, w_cb;
    logic signed [17:0] w_diff;

    always_comb begin
        w_qi   = (r_k >= 4'd6) ? 2'(r_k - 4'd6) : r_k[1:0];
        w_qa   = comp16(r_ka.rotation, w_qi);
        w_qb   = comp16(r_kb.rotation, w_qi);
        w_qb17 = r_negb ? -{w_qb[15], w_qb} : {w_qb[15], w_qb};
        if (r_k < 4'd3) begin
            w_ca = {w_qa[15], comp16({16'b0, r_ka.position}, r_k[1:0])};
            w_cb = {w_qa[15], comp16({16'b0, r_kb.position}, r_k[1:0])};
            w_ca[16] = w_ca[15];
            w_cb[16] = w_cb[15];
        end else if (r_k < 4'd6) begin
            w_ca = {1'b0, comp16({16'b0, r_ka.scale}, 2'(r_k - 4'd3))};
            w_cb = {1'b0, comp16({16'b0, r_kb.scale}, 2'(r_k - 4'd3))};
            w_ca[16] = w_ca[15];
            w_cb[16] = w_cb[15];
        end else begin
            w_ca = {w_qa[15], w_qa};
            w_cb = w_qb17;
        end
        w_diff = {w_cb[16], w_cb} - {w_ca[16], w_ca};
    end

    // shared multiplier operands
    logic signed [33:0] w_ma;
    logic signed [28:0] w_mb;
    logic [16:0]        w_tinv;

    assign w_tinv = 17'h10000 - r_t;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_LMUL: begin
                w_ma = {{16{w_diff[17]}}, w_diff};
                w_mb = {12'b0, r_t};
            end
            S_DMUL: begin
                w_ma = {{18{w_qa[15]}}, w_qa};
                w_mb = {{12{w_qb17[16]}}, w_qb17};
            end
            S_SQMUL: begin
                w_ma = {6'b0, r_d};
                w_mb = {1'b0, r_d};
            end
            S_AMUL0: begin
                w_ma = r_cz;
                w_mb = {12'b0, w_tinv};
            end
            S_AMUL1: begin
                w_ma = r_cz;
                w_mb = {12'b0, r_t};
            end
            S_NMUL0: begin
                w_ma = r_sa;
                w_mb = {{13{w_qa[15]}}, w_qa};
            end
            S_NMUL1: begin
                w_ma = r_cy;
                w_mb = {{12{w_qb17[16]}}, w_qb17};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // datapath combinational helpers
    logic signed [49:0] w_rnd, w_rsh, w_caext, w_mixv;
    logic [32:0]        w_r2;
    logic               w_dge;
    logic signed [49:0] w_dabs;
    logic [57:0]        w_bit;
    logic [58:0]        w_trial;
    logic               w_sqge;
    logic [57:0]        w_res_nx;
    logic signed [33:0] w_xs, w_ys, w_atan, w_cx_nx, w_cy_nx, w_cz_nx;
    logic               w_up;
    logic signed [49:0] w_num, w_mag;
    logic [49:0]        w_dsh;
    logic               w_qge;
    logic [17:0]        w_qc;
    logic signed [49:0] w_qval;
    logic               w_cord_last;

    always_comb begin
        w_rnd   = r_prod[49:0] + 50'sd32768;
        w_rsh   = w_rnd >>> 16;
        w_caext = {{33{w_ca[16]}}, w_ca};
        w_mixv  = w_caext + w_rsh;

        w_r2  = {r_rem, 1'b0};
        w_dge = w_r2 >= {1'b0, r_den};

        w_dabs = r_acc[49] ? -r_acc : r_acc;

        w_bit    = 58'(1) << {r_cnt, 1'b0};
        w_trial  = {1'b0, r_res} + {1'b0, w_bit};
        w_sqge   = {2'b0, r_sqv} >= w_trial;
        w_res_nx = w_sqge ? ((r_res >> 1) + w_bit) : (r_res >> 1);

        // one cordic step, vectoring in phase zero and rotation otherwise
        w_xs    = r_cx >>> r_cnt;
        w_ys    = r_cy >>> r_cnt;
        w_atan  = atan_q30(r_cnt);
        w_up    = (r_phase == 2'd0) ? (r_cy > 34'sd0) : r_cz[33];
        w_cx_nx = w_up ? (r_cx + w_ys) : (r_cx - w_ys);
        w_cy_nx = w_up ? (r_cy - w_xs) : (r_cy + w_xs);
        w_cz_nx = w_up ? (r_cz + w_atan) : (r_cz - w_atan);
        w_cord_last = (r_cnt == ITER_LAST);

        w_num = r_acc + r_prod[49:0];
        w_mag = w_num[49] ? -w_num : w_num;

        w_dsh = {19'b0, r_s, 2'b00} << r_cnt;
        w_qge = r_qrem >= w_dsh;

        w_qc   = (r_q > 18'd65536) ? 18'd65536 : r_q;
        w_qval = r_qneg ? -{32'b0, w_qc} : {32'b0, w_qc};
    end

    // state register and configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_count <= 6'd1;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_key_count <= i_cfg_wr_data;
            end
        end
    end

    // next state and handshake outputs
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_in_acc && (s_axis_tuser == FUNC_SAMPLE)) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: n_state = S_CHECK;
            S_CHECK: begin
                if (r_addr == '0) begin
                    n_state = (r_nlast == '0) ? S_OUT : S_FETCH;
                end else if ((r_st < w_rd.key_time) || (r_addr == r_nlast)) begin
                    n_state = S_TPREP;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_TPREP: begin
                if ((r_kb.key_time > r_ka.key_time) && (r_st > r_ka.key_time)
                        && (r_st < r_kb.key_time)) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_LMUL;
                end
            end
            S_DIV:   n_state = (r_cnt == '0) ? S_LMUL : S_DIV;
            S_LMUL:  n_state = S_LACC;
            S_LACC: begin
                priority if (r_k == 4'd5) begin
                    n_state = S_DMUL;
                end else if (r_k == 4'd9) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_LMUL;
                end
            end
            S_DMUL:  n_state = S_DACC;
            S_DACC:  n_state = (r_k == 4'd3) ? S_DSIGN : S_DMUL;
            S_DSIGN: n_state = (w_dabs >= NEAR_ONE_Q28) ? S_LMUL : S_SQMUL;
            S_SQMUL: n_state = S_SQCAP;
            S_SQCAP: n_state = S_SQRT;
            S_SQRT:  n_state = (r_cnt == '0) ? S_CORD : S_SQRT;
            S_CORD: begin
                if (w_cord_last) begin
                    priority case (r_phase)
                        2'd0:    n_state = S_AMUL0;
                        2'd1:    n_state = S_CORD;
                        default: n_state = S_NMUL0;
                    endcase
                end
            end
            S_AMUL0: n_state = S_AMUL1;
            S_AMUL1: n_state = S_AMUL2;
            S_AMUL2: n_state = S_CORD;
            S_NMUL0: n_state = S_NMUL1;
            S_NMUL1: n_state = S_NMUL2;
            S_NMUL2: n_state = S_QDIV;
            S_QDIV:  n_state = (r_cnt == '0) ? S_QFIN : S_QDIV;
            S_QFIN:  n_state = (r_k == 4'd3) ? S_OUT : S_NMUL0;
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        unique case (r_state)
            S_IDLE: begin
                r_st    <= s_axis_tdata[228:197];
                r_nlast <= ADDR_W'(w_n - 32'd1);
                r_addr  <= '0;
                r_negb  <= 1'b0;
            end
            S_CHECK: begin
                if (r_addr == '0) begin
                    r_ka     <= w_rd;
                    r_pos    <= w_rd.position;
                    r_rot    <= w_rd.rotation;
                    r_scl    <= w_rd.scale;
                    r_status <= (r_st < w_rd.key_time) ? STATUS_BEFORE :
                                (r_st > w_rd.key_time) ? STATUS_AFTER : STATUS_INSIDE;
                    r_addr   <= ADDR_W'(1);
                end else begin
                    r_kb <= w_rd;
                    if (!((r_st < w_rd.key_time) || (r_addr == r_nlast))) begin
                        r_ka   <= w_rd;
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
            end
            S_TPREP: begin
                r_k   <= '0;
                r_rem <= r_st - r_ka.key_time;
                r_den <= r_kb.key_time - r_ka.key_time;
                r_cnt <= ITER_W'(15);
                priority if (r_kb.key_time <= r_ka.key_time) begin
                    r_t      <= '0;
                    r_status <= STATUS_ZERO;
                end else if (r_st <= r_ka.key_time) begin
                    r_t      <= '0;
                    r_status <= (r_st < r_ka.key_time) ? STATUS_BEFORE : STATUS_INSIDE;
                end else if (r_st >= r_kb.key_time) begin
                    r_t      <= 17'h10000;
                    r_status <= (r_st > r_kb.key_time) ? STATUS_AFTER : STATUS_INSIDE;
                end else begin
                    r_t      <= '0;
                    r_status <= STATUS_INSIDE;
                end
            end
            S_DIV: begin
                r_rem <= w_dge ? 32'(w_r2 - {1'b0, r_den}) : w_r2[31:0];
                r_t   <= {r_t[15:0], w_dge};
                r_cnt <= r_cnt - ITER_W'(1);
            end
            S_LACC: begin
                if (r_k < 4'd3) begin
                    r_pos[16*r_k[1:0] +: 16] <= sat16(w_mixv);
                end else if (r_k < 4'd6) begin
                    r_scl[16*(2'(r_k - 4'd3)) +: 16] <= sat16(w_mixv);
                end else begin
                    r_rot[16*w_qi +: 16] <= sat16(w_mixv);
                end
                if (r_k == 4'd5) begin
                    r_k   <= '0;
                    r_acc <= '0;
                end else begin
                    r_k <= r_k + 4'd1;
                end
            end
            S_DACC: begin
                r_acc <= r_acc + r_prod[49:0];
                r_k   <= (r_k == 4'd3) ? 4'd3 : r_k + 4'd1;
            end
            S_DSIGN: begin
                r_negb <= r_acc[49];
                r_d    <= w_dabs[27:0];
                r_k    <= 4'd6;
            end
            S_SQCAP: begin
                r_sqv <= 57'h100_0000_0000_0000 - r_prod[56:0];
                r_res <= '0;
                r_cnt <= ITER_W'(28);
            end
            S_SQRT: begin
                if (w_sqge) begin
                    r_sqv <= r_sqv - w_trial[56:0];
                end
                r_res <= w_res_nx;
                r_cnt <= r_cnt - ITER_W'(1);
                if (r_cnt == '0) begin
                    r_s     <= w_res_nx[28:0];
                    r_cx    <= {6'b0, r_d};
                    r_cy    <= {5'b0, w_res_nx[28:0]};
                    r_cz    <= '0;
                    r_cnt   <= '0;
                    r_phase <= 2'd0;
                end
            end
            S_CORD: begin
                r_cx  <= w_cx_nx;
                r_cy  <= w_cy_nx;
                r_cz  <= w_cz_nx;
                r_cnt <= r_cnt + ITER_W'(1);
                if (w_cord_last && (r_phase == 2'd1)) begin
                    // first sine done, start the second angle
                    r_sa    <= w_cy_nx;
                    r_cx    <= INV_GAIN_Q30;
                    r_cy    <= '0;
                    r_cz    <= r_angb;
                    r_cnt   <= '0;
                    r_phase <= 2'd2;
                end
                if (w_cord_last && (r_phase == 2'd2)) begin
                    r_k <= '0;
                end
            end
            S_AMUL1: begin
                r_sa <= r_prod[49:16];
            end
            S_AMUL2: begin
                r_angb  <= r_prod[49:16];
                r_cx    <= INV_GAIN_Q30;
                r_cy    <= '0;
                r_cz    <= r_sa;
                r_cnt   <= '0;
                r_phase <= 2'd1;
            end
            S_NMUL1: begin
                r_acc <= r_prod[49:0];
            end
            S_NMUL2: begin
                r_qneg <= w_num[49];
                r_qrem <= w_mag + {20'b0, r_s, 1'b0};
                r_q    <= '0;
                r_cnt  <= ITER_W'(17);
            end
            S_QDIV: begin
                if (w_qge) begin
                    r_qrem <= r_qrem - w_dsh;
                end
                r_q   <= {r_q[16:0], w_qge};
                r_cnt <= r_cnt - ITER_W'(1);
            end
            S_QFIN: begin
                r_rot[16*r_k[1:0] +: 16] <= sat16(w_qval);
                r_k <= r_k + 4'd1;
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tdata = {6'b0, r_status, r_scl, r_rot, r_pos};

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready and result valid together");

    a_sample_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (s_axis_tuser == FUNC_SAMPLE)) |=> (r_state == S_FETCH))
        else $error("sample word did not start the key search");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (s_axis_tuser == FUNC_LOAD)) |=> !m_axis_tvalid)
        else $error("load word produced a result");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_addr <= r_nlast))
        else $error("key search ran past the last key");
`endif

endmodule

`default_nettype wire
